@@ src/fstp_pkg.sv @@
// Shared types, constants and a helper function of the floppy stepper and track data port.
package fstp_pkg;

  localparam int TRACK_BYTES_DEF    = 3172;
  localparam int MAX_HALF_TRACK_DEF = 80;
  localparam int HT_W               = 7;

  localparam logic [7:0] WP_RESET     = 8'h80;
  localparam logic [7:0] RD_UNUSED    = 8'hFF;
  localparam logic [7:0] RD_READY     = 8'h80;
  localparam logic [3:0] BYTE_BITS    = 4'd8;
  localparam logic       OP_READ      = 1'b0;
  localparam logic       CFG_WP_DRV0  = 1'b0;

  typedef enum logic [1:0] {
    PORT_LATCH  = 2'd0,
    PORT_DATA   = 2'd1,
    PORT_STATUS = 2'd2,
    PORT_WPROT  = 2'd3
  } port_t;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_D0   = 2'd1,
    SEL_D1   = 2'd2
  } sel_t;

  // The even bits of the shift register form the packed byte, bit 14 first.
  function automatic logic [7:0] pack_byte(input logic [15:0] s);
    logic [7:0] v;
    for (int k = 0; k < 8; k++) begin
      v[k] = s[2*k];
    end
    return v;
  endfunction

endpackage

@@ src/fstp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module fstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fstp_clr.sv @@
// Clearing sweep that zeroes the track buffer one entry per cycle after reset.
module fstp_clr #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);

  logic          busy_r;
  logic [AW-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else if (busy_r) begin
      if (addr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end else begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign addr = addr_r;

endmodule

@@ src/floppy_stepper_and_track_data_port.sv @@
// Top level of the floppy stepper and track data port: bus access decode and track buffer.
// The result of an access is registered and presented in the cycle after its transfer.
// Throughput: one access per cycle unless the output stalls; a data read that reloads
// the shift register from the buffer holds off the next access until that byte is loaded.
// Reset: all state but the output data returns to its initial value, and a sweep over
// all TRACK_BYTES entries clears the buffer, taking no access; configuration writes are.
module floppy_stepper_and_track_data_port #(
  parameter int TRACK_BYTES    = fstp_pkg::TRACK_BYTES_DEF,
  parameter int MAX_HALF_TRACK = fstp_pkg::MAX_HALF_TRACK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [1:0]  in_port,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_load_request,
  output logic        out_store_request,
  output logic        out_request_drive,
  output logic [5:0]  out_request_track,
  output logic [11:0] out_store_start,
  output logic [11:0] out_store_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  import fstp_pkg::*;

  localparam int AW = $clog2(TRACK_BYTES);
  localparam int CW = $clog2(TRACK_BYTES + 1);
  localparam logic [HT_W-1:0] HT_MAX = HT_W'(MAX_HALF_TRACK);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == AW'(TRACK_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [7:0]      wp0_r, wp1_r;
  sel_t            sel_r, sel_nxt;
  logic [HT_W-1:0] ht_r [2];
  logic [HT_W-1:0] ht_nxt [2];
  logic            rdy_r, rdy_nxt;
  logic [15:0]     sr_r, sr_nxt;
  logic [3:0]      bc_r, bc_nxt;
  logic            ep_r, ep_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   ws_r, ws_nxt;
  logic [CW-1:0]   wc_r, wc_nxt;
  logic [7:0]      ll_r, ll_nxt;
  logic            load_pend_r;

  logic            out_valid_r;
  logic [7:0]      rd_r;
  logic            load_r, store_r, drv_r;
  logic [5:0]      trk_r;
  logic [11:0]     st_start_r, st_count_r;

  logic            acc;
  logic            clr_busy;
  logic [AW-1:0]   clr_addr;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  logic [7:0]      rd_c;
  logic            load_c, store_c, drv_c, mem_re, mem_we;
  logic [5:0]      trk_c;
  logic [AW-1:0]   waddr_c;
  logic [7:0]      wdata_c;
  logic [11:0]     st_start_c, st_count_c;
  sel_t            want;
  logic            dr;
  logic [HT_W-1:0] ht_v;
  logic            ph_ok;
  logic [1:0]      ph;
  logic [3:0]      ll_lo;
  logic            om, im;
  logic [15:0]     sh;

  assign acc       = in_valid && in_ready;
  assign in_ready  = !clr_busy && !load_pend_r && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  always_comb begin
    sel_nxt    = sel_r;
    ht_nxt     = ht_r;
    rdy_nxt    = rdy_r;
    sr_nxt     = sr_r;
    bc_nxt     = bc_r;
    ep_nxt     = ep_r;
    pos_nxt    = pos_r;
    ws_nxt     = ws_r;
    wc_nxt     = wc_r;
    ll_nxt     = ll_r;
    rd_c       = '0;
    load_c     = 1'b0;
    store_c    = 1'b0;
    drv_c      = 1'b0;
    trk_c      = '0;
    st_start_c = '0;
    st_count_c = '0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    waddr_c    = pos_r;
    wdata_c    = '0;
    want       = SEL_NONE;
    dr         = 1'b0;
    ht_v       = '0;
    ph_ok      = 1'b0;
    ph         = '0;
    ll_lo      = ll_r[3:0];
    om         = 1'b0;
    im         = 1'b0;
    sh         = '0;
    if (in_operation == OP_READ) begin
      rd_c = RD_UNUSED;
      unique case (port_t'(in_port))
        PORT_DATA: begin
          if (bc_r != 4'd0) begin
            if (rdy_r) begin
              bc_nxt = bc_r - 1'b1;
            end
            sh   = sr_r >> bc_nxt;
            rd_c = sh[7:0];
          end
          if (bc_nxt == 4'd0) begin
            mem_re = 1'b1;
            if (rdy_r) begin
              bc_nxt  = BYTE_BITS;
              pos_nxt = next_pos(pos_r);
            end
            rdy_nxt = 1'b0;
          end
        end
        PORT_STATUS: begin
          if (sel_r != SEL_NONE) begin
            rdy_nxt = 1'b1;
          end
          rd_c = rdy_nxt ? RD_READY : 8'h00;
        end
        PORT_WPROT: begin
          if (sel_r == SEL_D0) begin
            rd_c = wp0_r;
          end else if (sel_r == SEL_D1) begin
            rd_c = wp1_r;
          end
        end
        PORT_LATCH: begin
          rd_c = RD_UNUSED;
        end
        default: begin
          rd_c = RD_UNUSED;
        end
      endcase
    end else if (port_t'(in_port) == PORT_LATCH) begin
      want = in_write_data[4] ? SEL_D0 : (in_write_data[7] ? SEL_D1 : SEL_NONE);
      if (want != sel_r) begin
        sel_nxt = want;
        if (want != SEL_NONE) begin
          load_c  = 1'b1;
          pos_nxt = '0;
          wc_nxt  = '0;
        end
      end
      if (sel_nxt != SEL_NONE) begin
        dr   = (sel_nxt == SEL_D1);
        ht_v = ht_r[dr];
        unique case (in_write_data[3:0])
          4'h1: begin ph_ok = 1'b1; ph = 2'd0; end
          4'h2: begin ph_ok = 1'b1; ph = 2'd1; end
          4'h4: begin ph_ok = 1'b1; ph = 2'd2; end
          4'h8: begin ph_ok = 1'b1; ph = 2'd3; end
          default: begin ph_ok = 1'b0; ph = 2'd0; end
        endcase
        if (ph_ok) begin
          om = ll_lo[ph + 2'd1];
          im = ll_lo[ph + 2'd3];
          if (om || im) begin
            if (om) begin
              if (ht_v != '0) begin
                ht_v = ht_v - 1'b1;
              end
            end else if (ht_v < HT_MAX) begin
              ht_v = ht_v + 1'b1;
            end
            if (!ht_v[0]) begin
              load_c  = 1'b1;
              pos_nxt = '0;
              wc_nxt  = '0;
            end
          end
        end
        ht_nxt[dr] = ht_v;
        if (!in_write_data[6]) begin
          sr_nxt = {sr_r[14:0], ll_r[5] ^ in_write_data[5]};
          ep_nxt = ~ep_r;
          if (!ep_nxt && bc_r != 4'd0) begin
            bc_nxt = bc_r - 1'b1;
            if (bc_nxt == 4'd0) begin
              mem_we  = 1'b1;
              waddr_c = pos_nxt;
              wdata_c = pack_byte(sr_nxt);
              pos_nxt = next_pos(pos_nxt);
              if (wc_nxt < CW'(TRACK_BYTES)) begin
                wc_nxt = wc_nxt + 1'b1;
              end
              bc_nxt = BYTE_BITS;
            end
          end
        end
        if (ll_r[6] ^ in_write_data[6]) begin
          if (ll_r[6]) begin
            ws_nxt = pos_nxt;
            ep_nxt = 1'b0;
          end else if (wc_nxt != '0) begin
            store_c    = 1'b1;
            st_start_c = 12'(ws_r);
            st_count_c = 12'(wc_nxt);
          end
          bc_nxt = BYTE_BITS;
          wc_nxt = '0;
        end
      end
      ll_nxt = in_write_data;
    end
    if ((load_c || store_c) && sel_nxt != SEL_NONE) begin
      drv_c = (sel_nxt == SEL_D1);
      trk_c = ht_nxt[drv_c][HT_W-1:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp0_r <= WP_RESET;
      wp1_r <= WP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WP_DRV0) begin
        wp0_r <= cfg_data;
      end else begin
        wp1_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= SEL_NONE;
      ht_r[0]     <= HT_MAX;
      ht_r[1]     <= HT_MAX;
      rdy_r       <= 1'b0;
      sr_r        <= '0;
      bc_r        <= BYTE_BITS;
      ep_r        <= 1'b0;
      pos_r       <= '0;
      ws_r        <= '0;
      wc_r        <= '0;
      ll_r        <= '0;
      load_pend_r <= 1'b0;
    end else if (acc) begin
      sel_r       <= sel_nxt;
      ht_r        <= ht_nxt;
      rdy_r       <= rdy_nxt;
      sr_r        <= sr_nxt;
      bc_r        <= bc_nxt;
      ep_r        <= ep_nxt;
      pos_r       <= pos_nxt;
      ws_r        <= ws_nxt;
      wc_r        <= wc_nxt;
      ll_r        <= ll_nxt;
      load_pend_r <= mem_re;
    end else if (load_pend_r) begin
      sr_r        <= {8'h00, ram_rdata};
      load_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r       <= rd_c;
      load_r     <= load_c;
      store_r    <= store_c;
      drv_r      <= drv_c;
      trk_r      <= trk_c;
      st_start_r <= st_start_c;
      st_count_r <= st_count_c;
    end
  end

  fstp_clr #(
    .DEPTH(TRACK_BYTES)
  ) u_clr (
    .clk  (clk),
    .rst_n(rst_n),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  assign ram_we    = clr_busy || (acc && mem_we);
  assign ram_waddr = clr_busy ? clr_addr : waddr_c;
  assign ram_wdata = clr_busy ? 8'h00 : wdata_c;

  fstp_ram #(
    .WIDTH(8),
    .DEPTH(TRACK_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pos_r),
    .rdata(ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_read_data     = rd_r;
  assign out_load_request  = load_r;
  assign out_store_request = store_r;
  assign out_request_drive = drv_r;
  assign out_request_track = trk_r;
  assign out_store_start   = st_start_r;
  assign out_store_count   = st_count_r;

`ifndef SYNTH
  a_store_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_store_request |-> out_store_count != 12'd0)
    else $error("store request with an empty run");

  a_half_track_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ht_r[0] <= HT_MAX && ht_r[1] <= HT_MAX)
    else $error("half-track counter beyond its limit");

  a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= BYTE_BITS)
    else $error("bit count beyond one byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= AW'(TRACK_BYTES - 1) && ws_r <= AW'(TRACK_BYTES - 1))
    else $error("buffer position outside the track");

  a_reload_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    load_pend_r |=> !load_pend_r)
    else $error("shift register reload held longer than one cycle");

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !(acc && mem_we))
    else $error("track write during the clearing sweep");
`endif

endmodule
